### src/slbq_pkg.sv
// ----------------------------------------------------------------------------
// Shelf and low-pass biquad cascade: shared definitions
// Widths, fixed-point constants, parameter defaults and register indexes.
// ----------------------------------------------------------------------------
package slbq_pkg;

    // Parameter defaults
    localparam int LOWPASS_STAGES_DEF = 2;
    localparam int SAMPLE_BITS_DEF    = 24;

    // Fixed-point layout
    localparam int COEF_W     = 32;   // signed Q4.28
    localparam int STATE_W    = 40;   // delay state, units of 2^-8 sample LSB
    localparam int ACC_W      = 48;   // accumulator, holds sums of three terms
    localparam int PROD_SHIFT = 20;   // product to state units
    localparam int OUT_SHIFT  = 8;    // state units to sample units

    // Configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;    // eight registers at 8-byte spacing
    localparam int REG_IDX_W  = 3;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SHELF_B0 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SHELF_B1 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SHELF_B2 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SHELF_A1 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SHELF_A2 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_LP_FF    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_LP_FB    = 3'd7;

    // Reset value of the shelf b0 coefficient: 1.0 in Q4.28
    localparam logic [COEF_W-1:0] SHELF_B0_RESET = 32'h1000_0000;

    // Input beat kinds (tuser)
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

endpackage

### src/shelf_and_lowpass_biquad_cascade_top.sv
// ----------------------------------------------------------------------------
// Shelf and low-pass biquad cascade
// Optional low-shelf biquad followed by an optional cascade of identical
// low-pass biquads, transposed direct form II, on one shared multiplier.
// ----------------------------------------------------------------------------
// A sample beat (tuser = 0) is taken only while the block is idle and runs
// through every enabled stage on one shared 32-bit by SAMPLE_BITS multiplier.
// Each enabled stage runs six steps (five products plus one drain step), and
// the done state then hands the beat to the output register; in pass-through
// mode the beat goes from the idle state straight to the done state. A clear
// beat (tuser = 1) zeroes all delay states and returns no beat. Every register
// write zeroes the delay states too; write registers only while no sample is
// in flight. The output register holds a finished beat until it is taken, so
// the block can accept the next sample meanwhile.
module shelf_and_lowpass_biquad_cascade_top #(
    parameter int LOWPASS_STAGES = slbq_pkg::LOWPASS_STAGES_DEF,
    parameter int SAMPLE_BITS    = slbq_pkg::SAMPLE_BITS_DEF,
    localparam int DATA_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [DATA_W-1:0]                s_axis_tdata,   // sample_in
    input  logic                             s_axis_tuser,   // op
    // output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [DATA_W-1:0]                m_axis_tdata,   // sample_out
    output logic                             m_axis_tuser,   // clipped
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [slbq_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [slbq_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [slbq_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int NST    = LOWPASS_STAGES + 1;
    localparam int STG_W  = $clog2(NST);
    localparam int SB     = SAMPLE_BITS;
    localparam int COEF_W = slbq_pkg::COEF_W;
    localparam int ST_W   = slbq_pkg::STATE_W;
    localparam int ACC_W  = slbq_pkg::ACC_W;
    localparam int PROD_W = COEF_W + SB;
    localparam int PSH    = slbq_pkg::PROD_SHIFT;
    localparam int OSH    = slbq_pkg::OUT_SHIFT;
    localparam int P_W    = PROD_W - PSH;

    localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) <<< (PSH - 1);
    localparam logic signed [ACC_W-1:0]  OUT_HALF  = ACC_W'(1) <<< (OSH - 1);
    localparam logic signed [ACC_W-1:0]  SMP_MAX   = (ACC_W'(1) <<< (SB - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0]  SMP_MIN   = -(ACC_W'(1) <<< (SB - 1));
    localparam logic signed [ACC_W-1:0]  ZST_MAX   = (ACC_W'(1) <<< (ST_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0]  ZST_MIN   = -(ACC_W'(1) <<< (ST_W - 1));
    localparam logic [STG_W-1:0]         LAST_STG  = STG_W'(LOWPASS_STAGES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef enum logic [2:0] {
        STEP_B0  = 3'd0,   // issue b0*x
        STEP_YA  = 3'd1,   // form b0*x + z1, issue b1*x
        STEP_Y   = 3'd2,   // round/saturate y, form b1*x + z2, issue b2*x
        STEP_B2  = 3'd3,   // hold b2*x, issue a1*y
        STEP_Z1  = 3'd4,   // write z1, issue a2*y
        STEP_Z2  = 3'd5    // write z2, advance stage
    } t_step;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic        [1:0]          r_mode;
    logic signed [COEF_W-1:0]   r_sh_b0, r_sh_b1, r_sh_b2, r_sh_a1, r_sh_a2;
    logic        [63:0]         r_lp_ff, r_lp_fb;
    logic signed [ST_W-1:0]     r_z1 [NST];
    logic signed [ST_W-1:0]     r_z2 [NST];

    t_state                     r_state;
    t_step                      r_step;
    logic        [STG_W-1:0]    r_stage;
    logic signed [SB-1:0]       r_x;
    logic signed [SB-1:0]       r_y;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    r_acc2;
    logic                       r_clip;
    logic                       r_out_valid;
    logic        [SB-1:0]       r_out_data;
    logic                       r_out_clip;

    // ------------------------------------------------------------------
    // Handshakes and configuration decode
    // ------------------------------------------------------------------
    logic                       w_in_acc;
    logic                       w_cfg_wr;
    logic [slbq_pkg::REG_IDX_W-1:0] w_idx;
    logic                       w_out_free;

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_cfg_wr      = psel && penable && pwrite;
    assign w_idx         = paddr[slbq_pkg::CFG_ADDR_W-1:3];
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DATA_W'(r_out_data);
    assign m_axis_tuser  = r_out_clip;

    // Read back register contents
    always_comb begin
        case (w_idx)
            slbq_pkg::REG_MODE:     prdata = 64'(r_mode);
            slbq_pkg::REG_SHELF_B0: prdata = 64'($unsigned(r_sh_b0));
            slbq_pkg::REG_SHELF_B1: prdata = 64'($unsigned(r_sh_b1));
            slbq_pkg::REG_SHELF_B2: prdata = 64'($unsigned(r_sh_b2));
            slbq_pkg::REG_SHELF_A1: prdata = 64'($unsigned(r_sh_a1));
            slbq_pkg::REG_SHELF_A2: prdata = 64'($unsigned(r_sh_a2));
            slbq_pkg::REG_LP_FF:    prdata = r_lp_ff;
            slbq_pkg::REG_LP_FB:    prdata = r_lp_fb;
            default:                prdata = '0;
        endcase
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= '0;
            r_sh_b0 <= slbq_pkg::SHELF_B0_RESET;
            r_sh_b1 <= '0;
            r_sh_b2 <= '0;
            r_sh_a1 <= '0;
            r_sh_a2 <= '0;
            r_lp_ff <= '0;
            r_lp_fb <= '0;
        end else if (w_cfg_wr) begin
            case (w_idx)
                slbq_pkg::REG_MODE:     r_mode  <= pwdata[1:0];
                slbq_pkg::REG_SHELF_B0: r_sh_b0 <= pwdata[COEF_W-1:0];
                slbq_pkg::REG_SHELF_B1: r_sh_b1 <= pwdata[COEF_W-1:0];
                slbq_pkg::REG_SHELF_B2: r_sh_b2 <= pwdata[COEF_W-1:0];
                slbq_pkg::REG_SHELF_A1: r_sh_a1 <= pwdata[COEF_W-1:0];
                slbq_pkg::REG_SHELF_A2: r_sh_a2 <= pwdata[COEF_W-1:0];
                slbq_pkg::REG_LP_FF:    r_lp_ff <= pwdata;
                slbq_pkg::REG_LP_FB:    r_lp_fb <= pwdata;
                default:                r_mode  <= r_mode;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Coefficients of the current stage
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] w_b0, w_b1, w_b2, w_a1, w_a2;
    logic                     w_is_shelf;

    assign w_is_shelf = (r_stage == '0);
    assign w_b0 = w_is_shelf ? r_sh_b0 : r_lp_ff[63:32];
    assign w_b1 = w_is_shelf ? r_sh_b1 : r_lp_ff[31:0];
    assign w_b2 = w_is_shelf ? r_sh_b2 : r_lp_ff[63:32];
    assign w_a1 = w_is_shelf ? r_sh_a1 : r_lp_fb[63:32];
    assign w_a2 = w_is_shelf ? r_sh_a2 : r_lp_fb[31:0];

    // ------------------------------------------------------------------
    // Shared multiplier: pick operands for the step
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] w_mul_c;
    logic signed [SB-1:0]     w_mul_d;

    always_comb begin
        case (r_step)
            STEP_B0: begin w_mul_c = w_b0; w_mul_d = r_x; end
            STEP_YA: begin w_mul_c = w_b1; w_mul_d = r_x; end
            STEP_Y:  begin w_mul_c = w_b2; w_mul_d = r_x; end
            STEP_B2: begin w_mul_c = w_a1; w_mul_d = r_y; end
            STEP_Z1: begin w_mul_c = w_a2; w_mul_d = r_y; end
            default: begin w_mul_c = w_b0; w_mul_d = r_x; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_mul_c) * PROD_W'(w_mul_d);
    end

    // ------------------------------------------------------------------
    // Product rounding, shared adder and subtractor, saturation
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] w_prnd;
    logic signed [ACC_W-1:0]  w_p;
    logic signed [ACC_W-1:0]  w_z1x, w_z2x;
    logic signed [ACC_W-1:0]  w_add;
    logic signed [ACC_W-1:0]  w_sub;
    logic signed [ACC_W-1:0]  w_yrnd;
    logic signed [ACC_W-1:0]  w_ysh;
    logic signed [SB-1:0]     w_ysat;
    logic                     w_yclip;
    logic signed [ST_W-1:0]   w_zsat;
    logic                     w_zclip;

    // Round the product half up into state units
    assign w_prnd = r_prod + PROD_HALF;
    assign w_p    = {{(ACC_W - P_W){w_prnd[PROD_W-1]}}, w_prnd[PROD_W-1:PSH]};
    assign w_z1x  = {{(ACC_W - ST_W){r_z1[r_stage][ST_W-1]}}, r_z1[r_stage]};
    assign w_z2x  = {{(ACC_W - ST_W){r_z2[r_stage][ST_W-1]}}, r_z2[r_stage]};

    // Add the pending delay state: z1 for y, z2 for the new z1
    assign w_add = w_p + ((r_step == STEP_YA) ? w_z1x : w_z2x);

    // Subtract the feedback product
    assign w_sub = ((r_step == STEP_Z2) ? r_acc2 : r_acc) - w_p;

    // Round the accumulator half up to sample units and saturate
    assign w_yrnd = r_acc + OUT_HALF;
    assign w_ysh  = w_yrnd >>> OSH;

    always_comb begin
        if (w_ysh > SMP_MAX) begin
            w_ysat  = SB'(SMP_MAX);
            w_yclip = 1'b1;
        end else if (w_ysh < SMP_MIN) begin
            w_ysat  = SB'(SMP_MIN);
            w_yclip = 1'b1;
        end else begin
            w_ysat  = SB'(w_ysh);
            w_yclip = 1'b0;
        end
    end

    always_comb begin
        if (w_sub > ZST_MAX) begin
            w_zsat  = ST_W'(ZST_MAX);
            w_zclip = 1'b1;
        end else if (w_sub < ZST_MIN) begin
            w_zsat  = ST_W'(ZST_MIN);
            w_zclip = 1'b1;
        end else begin
            w_zsat  = ST_W'(w_sub);
            w_zclip = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic w_last_stage;
    logic w_load_out;

    assign w_last_stage = (r_stage == LAST_STG) || (w_is_shelf && !r_mode[1]);
    assign w_load_out   = (r_state == ST_DONE) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STEP_B0;
            r_stage <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && (s_axis_tuser == slbq_pkg::OP_FILTER)) begin
                        r_step  <= STEP_B0;
                        r_stage <= r_mode[0] ? STG_W'(0) : STG_W'(1);
                        r_state <= (r_mode == 2'b00) ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN: begin
                    case (r_step)
                        STEP_B0: r_step <= STEP_YA;
                        STEP_YA: r_step <= STEP_Y;
                        STEP_Y:  r_step <= STEP_B2;
                        STEP_B2: r_step <= STEP_Z1;
                        STEP_Z1: r_step <= STEP_Z2;
                        default: begin
                            // advance to the next stage or finish
                            r_step <= STEP_B0;
                            if (w_last_stage) begin
                                r_state <= ST_DONE;
                            end else begin
                                r_stage <= r_stage + STG_W'(1);
                            end
                        end
                    endcase
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers of the running sample
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x    <= s_axis_tdata[SB-1:0];
            r_clip <= 1'b0;
        end else if (r_state == ST_RUN) begin
            case (r_step)
                STEP_YA: r_acc <= w_add;
                STEP_Y: begin
                    r_y    <= w_ysat;
                    r_acc  <= w_add;
                    r_clip <= r_clip | w_yclip;
                end
                STEP_B2: r_acc2 <= w_p;
                STEP_Z1: r_clip <= r_clip | w_zclip;
                STEP_Z2: begin
                    r_clip <= r_clip | w_zclip;
                    r_x    <= r_y;
                end
                default: r_acc <= r_acc;
            endcase
        end
    end

    // Delay states: clear on reset, clear beat or register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_wr ||
            (w_in_acc && (s_axis_tuser == slbq_pkg::OP_CLEAR))) begin
            for (int i = 0; i < NST; i++) begin
                r_z1[i] <= '0;
                r_z2[i] <= '0;
            end
        end else if (r_state == ST_RUN) begin
            if (r_step == STEP_Z1) begin
                r_z1[r_stage] <= w_zsat;
            end
            if (r_step == STEP_Z2) begin
                r_z2[r_stage] <= w_zsat;
            end
        end
    end

    // Output register: hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= r_x;
            r_out_clip <= r_clip;
        end
    end

endmodule
